[rtl/sst_pkg.sv]
// shared types, constants and codes for the spill slot hash table
package sst_pkg;

   localparam int unsigned TABLE_SLOTS_DEF = 64;
   localparam int unsigned VALUE_BITS_DEF  = 64;
   localparam int unsigned KEY_BITS        = 16;
   localparam int unsigned STAMP_BITS      = 8;
   localparam int unsigned CSR_DATA_BITS   = 64;
   localparam logic [KEY_BITS-1:0]   SPILL_START_RESET = 16'd256;
   localparam logic [STAMP_BITS-1:0] STAMP_NONE        = 8'd255;

   typedef enum logic [2:0] {
      FUNC_SPILL   = 3'd0,
      FUNC_SET     = 3'd1,
      FUNC_RESERVE = 3'd2,
      FUNC_UNSPILL = 3'd3,
      FUNC_REMOVE  = 3'd4,
      FUNC_OLDEST  = 3'd5,
      FUNC_STATS   = 3'd6,
      FUNC_NOP     = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NOTFOUND = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   localparam logic CSR_SPILL_START   = 1'b0;
   localparam logic CSR_RESERVE_VALUE = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;     // capture request beat
      logic probe_init;   // start probe at home slot
      logic probe_step;   // advance probe one slot
      logic scan_init;    // start oldest scan at slot 0
      logic scan_step;    // compare and advance scan
      logic rd_issue;     // read slot at probe or scan address
      logic commit;       // apply the operation outcome
      logic rsp_load;     // load result register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic key_zero;
      logic rd_empty;     // slot read is empty and not a tombstone
      logic rd_match;     // slot read holds the key
      logic probe_last;   // probe has visited every slot
      logic scan_last;
   } sts_type;

endpackage

[rtl/sst_ram.sv]
// generic single port ram with registered read
module sst_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule

[rtl/sst_ctrl.sv]
// operation sequencer for the spill slot hash table
module sst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [2:0]        func_q,
   input  sst_pkg::sts_type  sts,
   output sst_pkg::cmd_type  cmd
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_START = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_SCAN  = 7'b0010000,
      ST_DONE  = 7'b0100000,
      ST_RSP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_START;
            end
         end
         ST_START: begin
            case (func_q)
               sst_pkg::FUNC_SPILL, sst_pkg::FUNC_SET, sst_pkg::FUNC_RESERVE,
               sst_pkg::FUNC_UNSPILL, sst_pkg::FUNC_REMOVE: begin
                  if (sts.key_zero && func_q != sst_pkg::FUNC_SPILL) begin
                     state_in = ST_DONE;
                  end else begin
                     cmd.probe_init = 1'b1;
                     state_in       = ST_READ;
                  end
               end
               sst_pkg::FUNC_OLDEST: begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_READ;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = (func_q == sst_pkg::FUNC_OLDEST) ? ST_SCAN : ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.rd_match || sts.rd_empty || sts.probe_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.probe_step = 1'b1;
               state_in       = ST_READ;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            state_in      = sts.scan_last ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            cmd.commit = 1'b1;
            state_in   = ST_RSP;
         end
         ST_RSP: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

[rtl/sst_dp.sv]
// table storage, probe and scan datapath
module sst_dp #(
   parameter int unsigned TABLE_SLOTS = sst_pkg::TABLE_SLOTS_DEF,
   parameter int unsigned VALUE_BITS  = sst_pkg::VALUE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sst_pkg::cmd_type     cmd,
   output sst_pkg::sts_type     sts,
   output logic [2:0]           func_q,
   input  logic                 csr_valid,
   input  logic                 csr_index,
   input  logic [63:0]          csr_data,
   input  logic [2:0]           req_func,
   input  logic [15:0]          req_reg_id,
   input  logic [63:0]          req_value_in,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_id_out,
   output logic [63:0]          rsp_value_out,
   output logic [6:0]           rsp_live_count
);
   localparam int unsigned AW = $clog2(TABLE_SLOTS);
   localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
   localparam int unsigned LIMIT = TABLE_SLOTS * 3;

   logic [2:0]            func_ff;
   logic [15:0]           key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff;
   logic [15:0]           next_id_ff, next_id_in;
   logic [VALUE_BITS-1:0] reserve_ff;
   logic [7:0]            clock_ff;
   logic [CW-1:0]         used_ff, dead_ff;
   logic [TABLE_SLOTS-1:0] live_ff, dead_bits_ff;
   logic [AW-1:0]         addr_ff, tomb_ff;
   logic                  tomb_ok_ff;
   logic [CW-1:0]         cnt_ff;
   logic                  hit_ff, found_ff;
   logic [7:0]            best_ff;
   logic [15:0]           best_id_ff;
   logic [1:0]            status_ff;
   logic [15:0]           id_ff;
   logic [63:0]           vout_ff;

   logic [15:0]           rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic [7:0]            rd_stamp;
   logic                  we_key, we_val, we_stamp;
   logic [AW-1:0]         waddr;
   logic [15:0]           wkey;
   logic [VALUE_BITS-1:0] wval;
   logic [AW-1:0]         ram_addr;
   logic                  is_put, room, ins_ok, slot_live;
   logic [AW-1:0]         ins_addr;
   logic [1:0]            st;
   logic [CW+1:0]         fill_x4;

   assign func_q = func_ff;
   // spill uses next id, bumped past zero
   assign key_in = (req_func == sst_pkg::FUNC_SPILL) ?
                   ((next_id_ff == 16'd0) ? 16'd1 : next_id_ff) : req_reg_id;

   assign slot_live = live_ff[addr_ff];
   assign sts.key_zero   = (key_ff == 16'd0);
   assign sts.rd_match   = slot_live && (rd_key == key_ff);
   assign sts.rd_empty   = !slot_live && !dead_bits_ff[addr_ff];
   assign sts.probe_last = (cnt_ff == CW'(TABLE_SLOTS - 1));
   assign sts.scan_last  = (addr_ff == AW'(TABLE_SLOTS - 1));

   assign is_put = (func_ff == sst_pkg::FUNC_SPILL) || (func_ff == sst_pkg::FUNC_SET) ||
                   (func_ff == sst_pkg::FUNC_RESERVE);
   assign fill_x4 = {(CW+2)'(used_ff) + (CW+2)'(dead_ff) + (CW+2)'(1)} << 2;
   assign room    = ({2'b0, fill_x4} <= (CW+4)'(LIMIT));
   assign ins_addr = tomb_ok_ff ? tomb_ff : addr_ff;
   // insert path: tombstone always, empty slot only below load limit
   assign ins_ok  = !hit_ff && (tomb_ok_ff || (found_ff && room));

   assign ram_addr = (cmd.commit) ? waddr : addr_ff;

   always_comb begin
      we_key = 1'b0; we_val = 1'b0; we_stamp = 1'b0;
      waddr = addr_ff; wkey = key_ff; wval = val_ff;
      st = sst_pkg::STATUS_OK;
      if (cmd.commit) begin
         case (func_ff)
            sst_pkg::FUNC_SPILL, sst_pkg::FUNC_SET, sst_pkg::FUNC_RESERVE: begin
               if (sts.key_zero) begin
                  st = sst_pkg::STATUS_NOTFOUND;
               end else if (hit_ff) begin
                  we_val = 1'b1; we_stamp = 1'b1;
               end else if (ins_ok) begin
                  waddr = ins_addr;
                  we_key = 1'b1; we_val = 1'b1; we_stamp = 1'b1;
               end else begin
                  st = sst_pkg::STATUS_FULL;
               end
            end
            sst_pkg::FUNC_UNSPILL: begin
               if (sts.key_zero || !hit_ff) st = sst_pkg::STATUS_NOTFOUND;
               else we_stamp = 1'b1;
            end
            sst_pkg::FUNC_REMOVE: begin
               if (sts.key_zero || !hit_ff) st = sst_pkg::STATUS_NOTFOUND;
            end
            default: st = sst_pkg::STATUS_OK;
         endcase
      end
   end

   sst_ram #(.WIDTH(16), .DEPTH(TABLE_SLOTS)) u_key (
      .clock(clock), .we(we_key), .addr(ram_addr), .wdata(wkey), .rdata(rd_key));
   sst_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_SLOTS)) u_val (
      .clock(clock), .we(we_val), .addr(ram_addr), .wdata(wval), .rdata(rd_val));
   sst_ram #(.WIDTH(8), .DEPTH(TABLE_SLOTS)) u_stamp (
      .clock(clock), .we(we_stamp), .addr(ram_addr), .wdata(clock_ff), .rdata(rd_stamp));

   always_comb begin
      next_id_in = next_id_ff;
      if (cmd.load_req && req_func == sst_pkg::FUNC_SPILL && next_id_ff == 16'd0) begin
         next_id_in = 16'd1;
      end
      if (cmd.commit && st == sst_pkg::STATUS_OK && is_put) begin
         if (func_ff == sst_pkg::FUNC_SPILL) next_id_in = key_ff + 16'd1;
         else if (func_ff == sst_pkg::FUNC_RESERVE && key_ff >= next_id_ff)
            next_id_in = key_ff + 16'd1;
      end
      // a spill start write reloads the id counter
      if (csr_valid && csr_index == sst_pkg::CSR_SPILL_START) begin
         next_id_in = csr_data[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff     <= sst_pkg::SPILL_START_RESET;
         reserve_ff     <= '0;
         clock_ff       <= '0;
         used_ff        <= '0;
         dead_ff        <= '0;
         live_ff        <= '0;
         dead_bits_ff   <= '0;
         func_ff        <= sst_pkg::FUNC_NOP;
      end else begin
         next_id_ff <= next_id_in;
         if (csr_valid && csr_index == sst_pkg::CSR_RESERVE_VALUE) begin
            reserve_ff <= csr_data[VALUE_BITS-1:0];
         end
         if (cmd.load_req) func_ff <= req_func;
         if (cmd.commit && st == sst_pkg::STATUS_OK) begin
            if (is_put || func_ff == sst_pkg::FUNC_UNSPILL) clock_ff <= clock_ff + 8'd1;
            if (is_put && !hit_ff) begin
               live_ff[ins_addr]      <= 1'b1;
               dead_bits_ff[ins_addr] <= 1'b0;
               used_ff <= used_ff + CW'(1);
               if (tomb_ok_ff) dead_ff <= dead_ff - CW'(1);
            end
            if (func_ff == sst_pkg::FUNC_REMOVE) begin
               live_ff[addr_ff]      <= 1'b0;
               dead_bits_ff[addr_ff] <= 1'b1;
               used_ff <= used_ff - CW'(1);
               dead_ff <= dead_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         key_ff <= key_in;
         val_ff <= (req_func == sst_pkg::FUNC_RESERVE) ? reserve_ff :
                   req_value_in[VALUE_BITS-1:0];
      end
      if (cmd.probe_init) begin
         addr_ff    <= key_ff[AW-1:0];
         cnt_ff     <= '0;
         tomb_ok_ff <= 1'b0;
         hit_ff     <= 1'b0;
         found_ff   <= 1'b0;
      end
      if (cmd.scan_init) begin
         addr_ff    <= '0;
         best_ff    <= sst_pkg::STAMP_NONE;
         best_id_ff <= '0;
      end
      // probe check happens in the cycle after the read
      if (!cmd.rd_issue && !cmd.load_req && !cmd.probe_init && !cmd.scan_init &&
          !cmd.commit && !cmd.rsp_load && !cmd.scan_step) begin
         if (sts.rd_match) hit_ff <= 1'b1;
         else if (sts.rd_empty) found_ff <= 1'b1;
         else if (!slot_live && !tomb_ok_ff) begin
            tomb_ok_ff <= 1'b1;
            tomb_ff    <= addr_ff;
         end
      end
      if (cmd.probe_step) begin
         addr_ff <= addr_ff + AW'(1);
         cnt_ff  <= cnt_ff + CW'(1);
      end
      if (cmd.scan_step) begin
         if (slot_live && rd_stamp < best_ff) begin
            best_ff    <= rd_stamp;
            best_id_ff <= rd_key;
         end
         addr_ff <= addr_ff + AW'(1);
      end
      if (cmd.commit) begin
         status_ff <= st;
         id_ff     <= (func_ff == sst_pkg::FUNC_SPILL && st == sst_pkg::STATUS_OK) ? key_ff :
                      (func_ff == sst_pkg::FUNC_OLDEST) ? best_id_ff : 16'd0;
         vout_ff   <= (func_ff == sst_pkg::FUNC_UNSPILL && st == sst_pkg::STATUS_OK) ?
                      64'(rd_val) : 64'd0;
      end
      if (cmd.rsp_load) begin
         rsp_status     <= status_ff;
         rsp_id_out     <= id_ff;
         rsp_value_out  <= vout_ff;
         rsp_live_count <= 7'(used_ff);
      end
   end
endmodule

[rtl/spill_slot_hash_table_core.sv]
// top level of the spill slot hash table
// sequence: start, then a read and a check per probed slot, then commit and result load
// throughput: one operation at a time, next beat taken in the cycle after the result loads
// the result register frees the request side once the result is loaded
// reset: sync active high; clears occupancy bits, counters, reserve csr, handshakes
// value and stamp rams are undefined until written and need no clearing pass
module spill_slot_hash_table_core #(
   parameter int unsigned TABLE_SLOTS = sst_pkg::TABLE_SLOTS_DEF,
   parameter int unsigned VALUE_BITS  = sst_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_reg_id,
   input  logic [63:0] req_value_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_id_out,
   output logic [63:0] rsp_value_out,
   output logic [6:0]  rsp_live_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);
   sst_pkg::cmd_type cmd;
   sst_pkg::sts_type sts;
   logic [2:0]       func_q;

   // csr beats are always taken
   assign csr_ready = 1'b1;

   sst_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .func_q(func_q), .sts(sts), .cmd(cmd));

   sst_dp #(.TABLE_SLOTS(TABLE_SLOTS), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .func_q(func_q),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .req_func(req_func), .req_reg_id(req_reg_id), .req_value_in(req_value_in),
      .rsp_status(rsp_status), .rsp_id_out(rsp_id_out),
      .rsp_value_out(rsp_value_out), .rsp_live_count(rsp_live_count));

   // a result beat only appears after a result load
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.rsp_load))
      else $error("result beat without load");

   // never accept while busy
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> !req_stall)
      else $error("request taken while busy");

   // status is never an unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status");
endmodule

[tb/sv/sst_checker.sv]
// checker for the spill slot hash table: tracks table contents, predicts and compares results
module sst_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_reg_id,
   input  logic [63:0] req_value_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_id_out,
   input  logic [63:0] rsp_value_out,
   input  logic [6:0]  rsp_live_count,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data,
   output int          error_count,
   output int          pending,
   output int          checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = sst_pkg::TABLE_SLOTS_DEF;

   typedef struct {
      sst_pkg::status_type status;
      logic [15:0]         id;
      logic [63:0]         value;
      logic [6:0]          live;
   } table_result_type;

   table_result_type expected_results[$];

   logic [15:0] key_mem[SLOTS];
   bit          dead_mem[SLOTS];
   logic [63:0] value_mem[SLOTS];
   logic [7:0]  stamp_mem[SLOTS];
   logic [15:0] next_id, spill_start;
   logic [63:0] reserve_value;
   logic [7:0]  use_clock;
   int          live_slots, tomb_slots;

   // slot holding key (hit set), else insertion slot, else -1
   function automatic int find_slot(input logic [15:0] k, output bit hit);
      int home, tomb, idx;
      hit = 0;
      home = k % SLOTS;
      tomb = -1;
      for (int i = 0; i < SLOTS; i++) begin
         idx = (home + i) % SLOTS;
         if (key_mem[idx] == 0) begin
            if (!dead_mem[idx]) return (tomb >= 0) ? tomb : idx;
            if (tomb < 0) tomb = idx;
         end else if (key_mem[idx] == k) begin
            hit = 1;
            return idx;
         end
      end
      return tomb;
   endfunction

   function automatic sst_pkg::status_type store_entry(input logic [15:0] k,
                                                       input logic [63:0] v);
      bit hit;
      int idx;
      if (k == 0) return sst_pkg::STATUS_NOTFOUND;
      idx = find_slot(k, hit);
      if (idx < 0) return sst_pkg::STATUS_FULL;
      if (!hit) begin
         if (dead_mem[idx]) begin
            dead_mem[idx] = 0;
            tomb_slots--;
         end else if ((live_slots + tomb_slots + 1) * 4 > SLOTS * 3) begin
            return sst_pkg::STATUS_FULL;
         end
         key_mem[idx] = k;
         live_slots++;
      end
      value_mem[idx] = v;
      stamp_mem[idx] = use_clock;
      use_clock++;
      return sst_pkg::STATUS_OK;
   endfunction

   function automatic table_result_type apply_op(input sst_pkg::func_type f,
                                                 input logic [15:0] k,
                                                 input logic [63:0] v);
      table_result_type r;
      bit hit;
      int idx;
      logic [7:0] best;
      logic [15:0] id;
      r.status = sst_pkg::STATUS_OK;
      r.id = 0;
      r.value = 0;
      case (f)
         sst_pkg::FUNC_SPILL: begin
            if (next_id == 0) next_id = 1;
            id = next_id;
            r.status = store_entry(id, v);
            if (r.status == sst_pkg::STATUS_OK) begin
               next_id = id + 16'd1;
               r.id = id;
            end
         end
         sst_pkg::FUNC_SET: r.status = store_entry(k, v);
         sst_pkg::FUNC_RESERVE: begin
            r.status = store_entry(k, reserve_value);
            if (r.status == sst_pkg::STATUS_OK && k >= next_id) next_id = k + 16'd1;
         end
         sst_pkg::FUNC_UNSPILL, sst_pkg::FUNC_REMOVE: begin
            idx = (k == 0) ? -1 : find_slot(k, hit);
            if (idx < 0 || !hit) begin
               r.status = sst_pkg::STATUS_NOTFOUND;
            end else if (f == sst_pkg::FUNC_UNSPILL) begin
               r.value = value_mem[idx];
               stamp_mem[idx] = use_clock;
               use_clock++;
            end else begin
               key_mem[idx] = 0;
               dead_mem[idx] = 1;
               live_slots--;
               tomb_slots++;
            end
         end
         sst_pkg::FUNC_OLDEST: begin
            best = sst_pkg::STAMP_NONE;
            for (int i = 0; i < SLOTS; i++)
               if (key_mem[i] != 0 && !dead_mem[i] && stamp_mem[i] < best) begin
                  best = stamp_mem[i];
                  r.id = key_mem[i];
               end
         end
         default: ;
      endcase
      r.live = live_slots[6:0];
      return r;
   endfunction

   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            key_mem[i] = 0;
            dead_mem[i] = 0;
         end
         spill_start = sst_pkg::SPILL_START_RESET;
         next_id = sst_pkg::SPILL_START_RESET;
         reserve_value = 0;
         use_clock = 0;
         live_slots = 0;
         tomb_slots = 0;
         expected_results.delete();
         error_count <= 0;
         checked <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected: status %0d id %h value %h live %0d",
                        $time, rsp_status, rsp_id_out, rsp_value_out, rsp_live_count);
               error_count <= error_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status || rsp_id_out !== want.id ||
                   rsp_value_out !== want.value || rsp_live_count !== want.live)
                  error_count <= error_count + 1;
               if (rsp_status !== want.status)
                  $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
               if (rsp_id_out !== want.id)
                  $display("%0t: id_out expected %h got %h", $time, want.id, rsp_id_out);
               if (rsp_value_out !== want.value)
                  $display("%0t: value_out expected %h got %h", $time, want.value,
                           rsp_value_out);
               if (rsp_live_count !== want.live)
                  $display("%0t: live_count expected %0d got %0d", $time, want.live,
                           rsp_live_count);
               checked <= checked + 1;
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == sst_pkg::CSR_SPILL_START) begin
               spill_start = csr_data[15:0];
               next_id = spill_start;
            end else begin
               reserve_value = csr_data;
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(apply_op(sst_pkg::func_type'(req_func), req_reg_id,
                                                req_value_in));
      end
      pending <= expected_results.size();
   end

endmodule

[tb/sv/testbench.sv]
// testbench top: drives operations and csr writes into the hash table core and gives the verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES     = 4;
   localparam int PHASE_OPS  = 375;
   localparam int DRAIN_WAIT = 2 * sst_pkg::TABLE_SLOTS_DEF + 40; // longest op is the oldest scan
   localparam int CYCLE_CAP  = 1000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_func = sst_pkg::FUNC_NOP;
   logic [15:0] req_reg_id = 0;
   logic [63:0] req_value_in = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_id_out;
   logic [63:0] rsp_value_out;
   logic [6:0]  rsp_live_count;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_index = sst_pkg::CSR_SPILL_START;
   logic [63:0] csr_data = 0;

   int error_count, pending, checked;
   int cycles = 0;
   int ops_sent = 0;
   int csr_writes = 0;
   int stall_left = 0;
   bit calm = 0;     // no idling on either side while set

   always #1 clock = ~clock;

   spill_slot_hash_table_core u_top (.*);

   sst_checker u_checker (.*);

   // run-away guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side back-pressure: a random stall before each beat, none in calm stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 0;
         if (rsp_valid && !rsp_stall) stall_left <= calm ? 0 : $urandom_range(0, 6);
      end
   end

   // one request beat; valid stays high across back-to-back beats
   task automatic send_op(input sst_pkg::func_type f, input logic [15:0] k,
                          input logic [63:0] v);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_reg_id <= k;
      req_value_in <= v;
      do @(posedge clock); while (req_stall);
      ops_sent++;
   endtask

   // park the request side until every result is back, then let the core settle
   task automatic drain();
      req_valid <= 0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [63:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      csr_writes++;
   endtask

   // mostly a small key pool so probes collide, wrap and hit tombstones
   function automatic logic [15:0] pick_key();
      if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, 100));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [63:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic random_op();
      int r;
      sst_pkg::func_type f;
      r = $urandom_range(0, 99);
      if (r < 15)      f = sst_pkg::FUNC_SPILL;
      else if (r < 40) f = sst_pkg::FUNC_SET;
      else if (r < 48) f = sst_pkg::FUNC_RESERVE;
      else if (r < 68) f = sst_pkg::FUNC_UNSPILL;
      else if (r < 85) f = sst_pkg::FUNC_REMOVE;
      else if (r < 92) f = sst_pkg::FUNC_OLDEST;
      else if (r < 97) f = sst_pkg::FUNC_STATS;
      else             f = sst_pkg::FUNC_NOP;
      send_op(f, pick_key(), pick_value());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed part, reset csr values
      send_op(sst_pkg::FUNC_STATS, 16'h0000, '0);
      send_op(sst_pkg::FUNC_OLDEST, 16'h0000, '0);          // empty table gives id zero
      send_op(sst_pkg::FUNC_UNSPILL, 16'h0000, '0);         // key zero is never found
      send_op(sst_pkg::FUNC_SET, 16'h0000, '1);
      send_op(sst_pkg::FUNC_REMOVE, 16'h0000, '0);
      send_op(sst_pkg::FUNC_RESERVE, 16'h0000, '0);
      send_op(sst_pkg::FUNC_SPILL, 16'h0000, '0);           // first auto id
      send_op(sst_pkg::FUNC_SET, 16'hFFFF, '1);             // home slot is the last one
      send_op(sst_pkg::FUNC_UNSPILL, 16'hFFFF, '0);
      send_op(sst_pkg::FUNC_SET, 16'h003F, 64'h5A5A_A5A5_0F0F_F0F0); // probe wraps to slot 0
      send_op(sst_pkg::FUNC_UNSPILL, 16'h003F, '0);
      send_op(sst_pkg::FUNC_REMOVE, 16'hFFFF, '0);          // leaves a tombstone
      send_op(sst_pkg::FUNC_UNSPILL, 16'h003F, '0);         // probe walks over it
      send_op(sst_pkg::FUNC_SET, 16'h007F, 64'h1);          // new key reuses the tombstone
      send_op(sst_pkg::FUNC_RESERVE, 16'h8000, '0);         // pushes next id past the key
      send_op(sst_pkg::FUNC_SPILL, 16'h0000, 64'h8000_0000_0000_0001);
      send_op(sst_pkg::FUNC_RESERVE, 16'hFFFF, '0);         // next id wraps to zero
      send_op(sst_pkg::FUNC_SET, 16'h0002, 64'h22);
      send_op(sst_pkg::FUNC_SPILL, 16'h0000, 64'h11);       // zero id skipped, gets id 1
      send_op(sst_pkg::FUNC_SPILL, 16'h0000, 64'h33);       // id 2 exists, updated in place
      send_op(sst_pkg::FUNC_OLDEST, 16'h0000, '0);
      send_op(sst_pkg::FUNC_UNSPILL, 16'h1234, '0);
      send_op(sst_pkg::FUNC_REMOVE, 16'h1234, '0);
      send_op(sst_pkg::FUNC_NOP, 16'hFFFF, '1);

      // random phases, each under its own csr setting
      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: begin
               csr_write(sst_pkg::CSR_SPILL_START, 64'hFFFF);
               csr_write(sst_pkg::CSR_RESERVE_VALUE, '1);
            end
            1: begin
               csr_write(sst_pkg::CSR_SPILL_START, 64'h1);
               csr_write(sst_pkg::CSR_RESERVE_VALUE, '0);
            end
            default: begin
               csr_write(sst_pkg::CSR_SPILL_START, 64'($urandom_range(1, 65535)));
               csr_write(sst_pkg::CSR_RESERVE_VALUE, {$urandom, $urandom});
            end
         endcase
         for (int n = 0; n < PHASE_OPS; n++) begin
            if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
            if (p == 2 && n == PHASE_OPS / 2) begin
               req_valid <= 0;
               do @(posedge clock); while (pending != 0);
            end
            random_op();
         end
      end

      req_valid <= 0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d operations and %0d csr writes; %0d results compared",
               ops_sent, csr_writes, checked);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
